/* src/owrs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owrs_pkg
// shared types, codes and sizes of the rom search engine
// ----------------------------------------------------------------------------
package owrs_pkg;

  localparam int ROM_BITS = 64;
  localparam int POS_W    = $clog2(ROM_BITS + 1);
  localparam int IDX_W    = $clog2(ROM_BITS);
  localparam int CODE_W   = 64;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_PREFIX = 2'd1,
    OP_BEGIN  = 2'd2,
    OP_PAIR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_CONTINUE = 3'd1,
    ST_FOUND    = 3'd2,
    ST_NONE     = 3'd3,
    ST_NODEV    = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [ROM_BITS-1:0] rom_bits;
    logic [POS_W-1:0]    disc_pos;
    logic                finished;
    logic [POS_W-1:0]    bit_pos;
    logic [POS_W-1:0]    zero_pos;
    logic                pass_active;
  } search_state_t;

  typedef struct packed {
    status_t             status;
    logic                direction;
    logic [CODE_W-1:0]   rom_code;
    logic                last_device;
  } result_t;

  function automatic search_state_t state_reset();
    search_state_t s;
    s.rom_bits    = '0;
    s.disc_pos    = '0;
    s.finished    = 1'b0;
    s.bit_pos     = POS_W'(1);
    s.zero_pos    = '0;
    s.pass_active = 1'b0;
    return s;
  endfunction

endpackage

`default_nettype wire

/* src/owrs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owrs_in_if / owrs_out_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface owrs_in_if;
  import owrs_pkg::*;
  logic       valid;
  logic       ready;
  op_t        op;
  logic [7:0] prefix_byte;
  logic       presence;
  logic       id_bit;
  logic       cmp_bit;

  modport source (output valid, op, prefix_byte, presence, id_bit, cmp_bit,
                  input ready);
  modport sink   (input valid, op, prefix_byte, presence, id_bit, cmp_bit,
                  output ready);
endinterface

interface owrs_out_if;
  import owrs_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic        direction;
  logic [63:0] rom_code;
  logic        last_device;

  modport source (output valid, status, direction, rom_code, last_device,
                  input ready);
  modport sink   (input valid, status, direction, rom_code, last_device,
                  output ready);
endinterface

`default_nettype wire

/* src/onewire_rom_search_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// an accepted command word has its result word registered for the next cycle
// throughput: one command word per cycle unless a held result word stalls
// it; the result register frees itself in the same cycle that its word is taken
// reset: synchronous active-low rst_n clears the search state, sets the
// bit position to one and empties the result register
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// step engine for the 1-wire rom search, one result word per command word
// ----------------------------------------------------------------------------
module onewire_rom_search_engine
  import owrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  owrs_in_if.sink           in_word,
  owrs_out_if.source        out_word
);

  search_state_t state_r;
  search_state_t state_nxt;
  result_t       res_nxt;
  result_t       res_r;
  logic          out_valid_r;
  logic          accept;

  assign in_word.ready = !out_valid_r || out_word.ready;
  assign accept        = in_word.valid && in_word.ready;

  owrs_step u_step (
    .st          (state_r),
    .op          (in_word.op),
    .prefix_byte (in_word.prefix_byte),
    .presence    (in_word.presence),
    .id_bit      (in_word.id_bit),
    .cmp_bit     (in_word.cmp_bit),
    .st_nxt      (state_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= state_reset();
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r <= state_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.status      = res_r.status;
  assign out_word.direction   = res_r.direction;
  assign out_word.rom_code    = res_r.rom_code;
  assign out_word.last_device = res_r.last_device;

endmodule

`default_nettype wire

/* src/owrs_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owrs_step
// next search state and result word for one command word
// ----------------------------------------------------------------------------
module owrs_step
  import owrs_pkg::*;
(
  input  search_state_t st,
  input  op_t           op,
  input  logic [7:0]    prefix_byte,
  input  logic          presence,
  input  logic          id_bit,
  input  logic          cmp_bit,
  output search_state_t st_nxt,
  output result_t       res
);

  logic [IDX_W-1:0]    idx;
  logic [POS_W-1:0]    pos_m1;
  logic                dir;
  logic [ROM_BITS-1:0] rom_new;
  logic [POS_W-1:0]    zero_new;

  assign pos_m1 = st.bit_pos - POS_W'(1);
  assign idx    = pos_m1[IDX_W-1:0];

  // branch choice for the current bit
  always_comb begin
    zero_new = st.zero_pos;
    if (id_bit != cmp_bit) begin
      dir = id_bit;
    end else begin
      if (st.bit_pos < st.disc_pos) begin
        dir = st.rom_bits[idx];
      end else begin
        dir = (st.bit_pos == st.disc_pos);
      end
      if (!dir) begin
        zero_new = st.bit_pos;
      end
    end
    rom_new      = st.rom_bits;
    rom_new[idx] = dir;
  end

  always_comb begin
    st_nxt          = st;
    res.status      = ST_ACCEPTED;
    res.direction   = 1'b0;
    res.rom_code    = '0;
    res.last_device = 1'b0;
    case (op)
      OP_CLEAR: begin
        st_nxt = state_reset();
      end
      OP_PREFIX: begin
        st_nxt.rom_bits    = ROM_BITS'(prefix_byte);
        st_nxt.disc_pos    = POS_W'(ROM_BITS);
        st_nxt.finished    = 1'b0;
        st_nxt.pass_active = 1'b0;
        st_nxt.bit_pos     = POS_W'(1);
        st_nxt.zero_pos    = '0;
      end
      OP_BEGIN: begin
        st_nxt.bit_pos  = POS_W'(1);
        st_nxt.zero_pos = '0;
        if (st.finished || !presence) begin
          st_nxt.disc_pos    = '0;
          st_nxt.finished    = 1'b0;
          st_nxt.pass_active = 1'b0;
          res.status         = ST_NODEV;
        end else begin
          st_nxt.pass_active = 1'b1;
        end
      end
      OP_PAIR: begin
        if (!st.pass_active) begin
          res.status = ST_IGNORED;
        end else if (id_bit && cmp_bit) begin
          st_nxt.disc_pos    = '0;
          st_nxt.finished    = 1'b0;
          st_nxt.pass_active = 1'b0;
          st_nxt.bit_pos     = POS_W'(1);
          res.status         = ST_NODEV;
        end else begin
          st_nxt.rom_bits = rom_new;
          st_nxt.zero_pos = zero_new;
          res.direction   = dir;
          if (st.bit_pos < POS_W'(ROM_BITS)) begin
            st_nxt.bit_pos = st.bit_pos + POS_W'(1);
            res.status     = ST_CONTINUE;
          end else begin
            st_nxt.pass_active = 1'b0;
            st_nxt.bit_pos     = POS_W'(1);
            if (rom_new[7:0] == 8'd0) begin
              st_nxt.disc_pos = '0;
              st_nxt.finished = 1'b0;
              res.status      = ST_NONE;
            end else begin
              st_nxt.disc_pos = zero_new;
              st_nxt.finished = (zero_new == '0);
              res.status      = ST_FOUND;
              res.rom_code    = CODE_W'(rom_new);
              res.last_device = (zero_new == '0);
            end
          end
        end
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
  end

endmodule

`default_nettype wire
